[sv/owtr_pkg.sv]
// Shared types and constants for the 1-Wire temperature reader.
// No dependencies.
package owtr_pkg;

    localparam int COUNT_BITS = 10;
    localparam int REG_BITS   = 10;
    localparam int LIM_BITS   = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;
    localparam int NUM_REGS   = 7;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] REG_RESET_RECOVER = 3'd2;
    localparam logic [2:0] REG_SLOT_START    = 3'd3;
    localparam logic [2:0] REG_WRITE_SLOT    = 3'd4;
    localparam logic [2:0] REG_READ_SAMPLE   = 3'd5;
    localparam logic [2:0] REG_READ_RECOVER  = 3'd6;

    localparam logic [REG_BITS-1:0] DEF_RESET_LOW     = 10'd430;
    localparam logic [REG_BITS-1:0] DEF_PRESENCE_WAIT = 10'd60;
    localparam logic [REG_BITS-1:0] DEF_RESET_RECOVER = 10'd420;
    localparam logic [REG_BITS-1:0] DEF_SLOT_START    = 10'd1;
    localparam logic [REG_BITS-1:0] DEF_WRITE_SLOT    = 10'd50;
    localparam logic [REG_BITS-1:0] DEF_READ_SAMPLE   = 10'd10;
    localparam logic [REG_BITS-1:0] DEF_READ_RECOVER  = 10'd40;

    localparam logic [7:0] ROM_SKIP     = 8'hCC;
    localparam logic [7:0] FN_CONVERT   = 8'h44;
    localparam logic [7:0] FN_READ_PAD  = 8'hBE;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_RLOW   = 3'd1,
        PH_RWAIT  = 3'd2,
        PH_RREC   = 3'd3,
        PH_SLOT   = 3'd4,
        PH_WHOLD  = 3'd5,
        PH_SAMPLE = 3'd6,
        PH_SREC   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_RESET   = 3'd1,
        CMD_WRITE   = 3'd2,
        CMD_READ    = 3'd3,
        CMD_BIT     = 3'd4,
        CMD_MEASURE = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        SEQ_IDLE  = 4'd0,
        SEQ_RST1  = 4'd1,
        SEQ_SKIP1 = 4'd2,
        SEQ_CONV  = 4'd3,
        SEQ_POLL  = 4'd4,
        SEQ_RST2  = 4'd5,
        SEQ_SKIP2 = 4'd6,
        SEQ_RDPAD = 4'd7,
        SEQ_LSB   = 4'd8,
        SEQ_MSB   = 4'd9,
        SEQ_RST3  = 4'd10
    } seq_t;

endpackage

[sv/onewire_master_temp_reader.sv]
// 1-Wire bus master with temperature measurement sequence, top level.
// Depends on owtr_pkg.
//
// Each input word is one microsecond tick carrying the sampled bus level; an
// action of 1 to 5 starts a command and that word is its first tick. A word
// is taken each clock cycle unless the output stalls and yields exactly one
// registered result word; the output register lets a new word in while the
// previous one is taken. Timing is set by the seven slot registers on the
// write port, which the user must load only while no command runs; the block
// does not enforce this. A command given while one runs is dropped and flagged.
module onewire_master_temp_reader (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], line_level[8], zero pad
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // drive_low[0], busy_res[1], done_res[2],
                                   // presence[3], read_data[19:4], rejected[20]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_wdata
);
    import owtr_pkg::*;

    logic [REG_BITS-1:0]   cfg_reg [NUM_REGS];
    phase_t                phase_reg, phase_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [2:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    seq_t                  seq_reg, seq_next;
    logic [15:0]           temp_reg, temp_next;
    logic                  pres_reg, pres_next;
    cmd_t                  cmd_reg, cmd_next;
    logic                  m_valid_reg;
    logic [23:0]           m_data_reg, m_data_next;

    logic                  accept;
    logic [2:0]            action;
    logic [7:0]            data_byte;
    logic                  line;
    logic                  drive, done, rej, ended, reads, byte_op;
    logic [15:0]           result;
    logic [REG_BITS-1:0]   lim_raw;
    logic [LIM_BITS-1:0]   lim_w;
    logic [COUNT_BITS-1:0] lim;

    assign action    = s_tuser;
    assign data_byte = s_tdata[7:0];
    assign line      = s_tdata[8];
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[REG_RESET_LOW]     <= DEF_RESET_LOW;
            cfg_reg[REG_PRESENCE_WAIT] <= DEF_PRESENCE_WAIT;
            cfg_reg[REG_RESET_RECOVER] <= DEF_RESET_RECOVER;
            cfg_reg[REG_SLOT_START]    <= DEF_SLOT_START;
            cfg_reg[REG_WRITE_SLOT]    <= DEF_WRITE_SLOT;
            cfg_reg[REG_READ_SAMPLE]   <= DEF_READ_SAMPLE;
            cfg_reg[REG_READ_RECOVER]  <= DEF_READ_RECOVER;
        end else if (cfg_we && (32'(cfg_index) < NUM_REGS)) begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            seq_reg     <= SEQ_IDLE;
            temp_reg    <= '0;
            pres_reg    <= 1'b0;
            cmd_reg     <= CMD_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                seq_reg   <= seq_next;
                temp_reg  <= temp_next;
                pres_reg  <= pres_next;
                cmd_reg   <= cmd_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        seq_next   = seq_reg;
        temp_next  = temp_reg;
        pres_next  = pres_reg;
        cmd_next   = cmd_reg;
        drive      = 1'b0;
        done       = 1'b0;
        rej        = 1'b0;
        ended      = 1'b0;
        result     = '0;
        lim_raw    = '0;
        reads      = 1'b0;
        byte_op    = 1'b0;

        // command start
        if (action >= 3'd1 && action <= 3'd5) begin
            if (cmd_reg != CMD_NONE) begin
                rej = 1'b1;
            end else begin
                cmd_next = cmd_t'(action);
                cnt_next = '0;
                unique case (cmd_t'(action))
                    CMD_RESET: phase_next = PH_RLOW;
                    CMD_WRITE: begin
                        shift_next = data_byte;
                        bit_next   = '0;
                        phase_next = PH_SLOT;
                    end
                    CMD_READ: begin
                        shift_next = '0;
                        bit_next   = '0;
                        phase_next = PH_SLOT;
                    end
                    CMD_BIT: begin
                        shift_next = '0;
                        phase_next = PH_SLOT;
                    end
                    default: begin
                        seq_next   = SEQ_RST1;
                        temp_next  = '0;
                        phase_next = PH_RLOW;
                    end
                endcase
            end
        end

        // slot timing
        unique case (phase_next)
            PH_RLOW:   lim_raw = cfg_reg[REG_RESET_LOW];
            PH_RWAIT:  lim_raw = cfg_reg[REG_PRESENCE_WAIT];
            PH_RREC:   lim_raw = cfg_reg[REG_RESET_RECOVER];
            PH_SLOT:   lim_raw = cfg_reg[REG_SLOT_START];
            PH_WHOLD:  lim_raw = cfg_reg[REG_WRITE_SLOT];
            PH_SAMPLE: lim_raw = cfg_reg[REG_READ_SAMPLE];
            PH_SREC:   lim_raw = cfg_reg[REG_READ_RECOVER];
            default:   lim_raw = '0;
        endcase
        lim_w = LIM_BITS'(lim_raw);
        if (lim_w == '0) lim_w = LIM_BITS'(1);
        if (lim_w > LIM_BITS'(CNT_MAX)) lim_w = LIM_BITS'(CNT_MAX);
        lim = lim_w[COUNT_BITS-1:0];

        reads = (cmd_next == CMD_READ) || (cmd_next == CMD_BIT) ||
                ((cmd_next == CMD_MEASURE) &&
                 (seq_next == SEQ_POLL || seq_next == SEQ_LSB || seq_next == SEQ_MSB));

        if (cmd_next != CMD_NONE && phase_next != PH_IDLE) begin
            drive = (phase_next == PH_RLOW) || (phase_next == PH_SLOT) ||
                    ((phase_next == PH_WHOLD) && !shift_next[0]);
            if (cnt_next != CNT_MAX) cnt_next = cnt_next + 1'b1;
            if (cnt_next >= lim) begin
                unique case (phase_next)
                    PH_RLOW: begin
                        phase_next = PH_RWAIT;
                        cnt_next   = '0;
                    end
                    PH_RWAIT: begin
                        pres_next  = !line;
                        phase_next = PH_RREC;
                        cnt_next   = '0;
                    end
                    PH_SLOT: begin
                        phase_next = reads ? PH_SAMPLE : PH_WHOLD;
                        cnt_next   = '0;
                    end
                    PH_WHOLD: begin
                        shift_next = {1'b0, shift_next[7:1]};
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                        ended      = 1'b1;
                    end
                    PH_SAMPLE: begin
                        shift_next = {line, shift_next[7:1]};
                        phase_next = PH_SREC;
                        cnt_next   = '0;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                        ended      = 1'b1;
                    end
                endcase
            end
        end

        // slot or reset finished
        if (ended) begin
            byte_op = (cmd_next == CMD_WRITE) || (cmd_next == CMD_READ) ||
                      ((cmd_next == CMD_MEASURE) &&
                       (seq_next == SEQ_SKIP1 || seq_next == SEQ_CONV ||
                        seq_next == SEQ_SKIP2 || seq_next == SEQ_RDPAD ||
                        seq_next == SEQ_LSB   || seq_next == SEQ_MSB));
            if (byte_op && bit_next != 3'd7) begin
                bit_next   = bit_next + 1'b1;
                phase_next = PH_SLOT;
                cnt_next   = '0;
            end else if (cmd_next == CMD_RESET || cmd_next == CMD_WRITE) begin
                done = 1'b1;
            end else if (cmd_next == CMD_READ) begin
                done   = 1'b1;
                result = {8'd0, shift_next};
            end else if (cmd_next == CMD_BIT) begin
                done   = 1'b1;
                result = {15'd0, shift_next[7]};
            end else begin
                cnt_next = '0;
                unique case (seq_next)
                    SEQ_RST1: begin
                        seq_next   = SEQ_SKIP1;
                        shift_next = ROM_SKIP;
                        bit_next   = '0;
                        phase_next = PH_SLOT;
                    end
                    SEQ_SKIP1: begin
                        seq_next   = SEQ_CONV;
                        shift_next = FN_CONVERT;
                        bit_next   = '0;
                        phase_next = PH_SLOT;
                    end
                    SEQ_CONV: begin
                        seq_next   = SEQ_POLL;
                        shift_next = '0;
                        phase_next = PH_SLOT;
                    end
                    SEQ_POLL: begin
                        if (shift_next[7]) begin
                            seq_next   = SEQ_RST2;
                            phase_next = PH_RLOW;
                        end else begin
                            shift_next = '0;
                            phase_next = PH_SLOT;
                        end
                    end
                    SEQ_RST2: begin
                        seq_next   = SEQ_SKIP2;
                        shift_next = ROM_SKIP;
                        bit_next   = '0;
                        phase_next = PH_SLOT;
                    end
                    SEQ_SKIP2: begin
                        seq_next   = SEQ_RDPAD;
                        shift_next = FN_READ_PAD;
                        bit_next   = '0;
                        phase_next = PH_SLOT;
                    end
                    SEQ_RDPAD: begin
                        seq_next   = SEQ_LSB;
                        shift_next = '0;
                        bit_next   = '0;
                        phase_next = PH_SLOT;
                    end
                    SEQ_LSB: begin
                        temp_next  = {8'd0, shift_next};
                        seq_next   = SEQ_MSB;
                        shift_next = '0;
                        bit_next   = '0;
                        phase_next = PH_SLOT;
                    end
                    SEQ_MSB: begin
                        temp_next  = {shift_next, temp_next[7:0]};
                        seq_next   = SEQ_RST3;
                        phase_next = PH_RLOW;
                    end
                    default: begin
                        done   = 1'b1;
                        result = temp_next;
                    end
                endcase
            end
            if (done) begin
                cmd_next   = CMD_NONE;
                seq_next   = SEQ_IDLE;
                phase_next = PH_IDLE;
                cnt_next   = '0;
            end
        end

        m_data_next = {3'd0, rej, result, pres_next, done, (cmd_next != CMD_NONE), drive};
    end

`ifndef ASSERT_OFF
    a_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_reg == CMD_NONE |-> phase_reg == PH_IDLE)
        else $error("bus phase active without a command");

    a_seq_measure: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg != SEQ_IDLE |-> cmd_reg == CMD_MEASURE)
        else $error("sequence step outside measure");

    a_data_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg[2] |-> m_data_reg[19:4] == 16'd0)
        else $error("read data without done");

    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[0] |-> m_data_reg[1] || m_data_reg[2])
        else $error("bus driven with no command");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && done |=> cmd_reg == CMD_NONE)
        else $error("command still held after done");
`endif

endmodule

[tb/sv/onewire_master_temp_reader_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the 1-Wire temperature reader: a directed table, then
// random command streams under several slot timings, each word checked in order.
// Depends on owtr_pkg and onewire_master_temp_reader.
module onewire_master_temp_reader_tb;
    import owtr_pkg::*;

    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam logic [2:0] REG_SPARE    = 3'd7;

    localparam int TS_KEEP = 0;
    localparam int TS_ZERO = 1;
    localparam int TS_LONG = 2;
    localparam int TS_ONE  = 3;

    localparam int RAND_PHASES = 4;
    localparam int PHASE_WORDS = 100;
    localparam int MAX_GAP     = 6;
    localparam int MAX_REPORTS = 40;

    typedef logic [NUM_REGS-1:0][REG_BITS-1:0] timing_t;
    localparam timing_t ZERO_TIMING = '0;
    localparam timing_t LONG_TIMING = {NUM_REGS{10'd6}};
    localparam timing_t ONE_TIMING  = {NUM_REGS{10'd1}};

    typedef struct packed {
        logic        rejected;
        logic [15:0] read_data;
        logic        presence;
        logic        done;
        logic        busy;
        logic        drive;
    } result_t;

    localparam result_t RES_IDLE      = '0;
    localparam result_t RES_SLOT_OPEN = '{rejected: 1'b0, read_data: 16'h0, presence: 1'b0,
                                          done: 1'b0, busy: 1'b1, drive: 1'b1};
    localparam result_t RES_REJECTED  = '{rejected: 1'b1, read_data: 16'h0, presence: 1'b0,
                                          done: 1'b0, busy: 1'b1, drive: 1'b0};

    typedef struct {
        logic [2:0] act;
        logic [7:0] data;
        logic       line;
        bit         known;
        result_t    want;
        bit         settle;
        int         timing_set;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [9:0]  cfg_wdata;

    // bus master model
    timing_t               lim_us;
    phase_t                bus_phase;
    logic [COUNT_BITS-1:0] us_count;
    logic [2:0]            bit_no;
    logic [7:0]            shifter;
    seq_t                  meas_step;
    logic [15:0]           temp_raw;
    logic                  device_seen;
    cmd_t                  running;

    result_t owed_results [$];
    int      mismatches = 0;
    bit      tx_calm = 1'b0;
    bit      rx_calm = 1'b0;

    onewire_master_temp_reader uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic void enter_phase(phase_t p);
        bus_phase = p;
        us_count  = '0;
    endfunction

    function automatic void start_byte(logic [7:0] v);
        shifter = v;
        bit_no  = '0;
        enter_phase(PH_SLOT);
    endfunction

    // one microsecond of slot timing; returns 1 when a reset or slot ends
    function automatic logic slot_tick(input logic line, output logic drv);
        logic [COUNT_BITS-1:0] lim;
        logic                  reads;
        drv = 1'b0;
        if (bus_phase == PH_IDLE) return 1'b0;
        drv = (bus_phase == PH_RLOW) || (bus_phase == PH_SLOT) ||
              (bus_phase == PH_WHOLD && !shifter[0]);
        lim = lim_us[bus_phase - 3'd1];
        if (lim == '0) lim = COUNT_BITS'(1);
        if (us_count != CNT_MAX) us_count = us_count + 1'b1;
        if (us_count < lim) return 1'b0;
        reads = (running == CMD_READ) || (running == CMD_BIT) ||
                (running == CMD_MEASURE && (meas_step == SEQ_POLL ||
                 meas_step == SEQ_LSB || meas_step == SEQ_MSB));
        case (bus_phase)
            PH_RLOW: begin
                enter_phase(PH_RWAIT);
                return 1'b0;
            end
            PH_RWAIT: begin
                device_seen = !line;
                enter_phase(PH_RREC);
                return 1'b0;
            end
            PH_SLOT: begin
                enter_phase(reads ? PH_SAMPLE : PH_WHOLD);
                return 1'b0;
            end
            PH_WHOLD: begin
                shifter = shifter >> 1;
                enter_phase(PH_IDLE);
                return 1'b1;
            end
            PH_SAMPLE: begin
                shifter = {line, shifter[7:1]};
                enter_phase(PH_SREC);
                return 1'b0;
            end
            default: begin
                enter_phase(PH_IDLE);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic result_t bus_master_step(logic [2:0] act, logic [7:0] data,
                                                logic line);
        result_t r;
        logic    ended;
        logic    drv;
        logic    byte_op;
        r = '0;
        if (act >= CMD_RESET && act <= CMD_MEASURE) begin
            if (running != CMD_NONE) begin
                r.rejected = 1'b1;
            end else begin
                running = cmd_t'(act);
                case (running)
                    CMD_RESET: enter_phase(PH_RLOW);
                    CMD_WRITE: start_byte(data);
                    CMD_READ:  start_byte(8'h00);
                    CMD_BIT: begin
                        shifter = '0;
                        enter_phase(PH_SLOT);
                    end
                    default: begin
                        meas_step = SEQ_RST1;
                        temp_raw  = '0;
                        enter_phase(PH_RLOW);
                    end
                endcase
            end
        end
        if (running != CMD_NONE) begin
            ended = slot_tick(line, drv);
            r.drive = drv;
            if (ended) begin
                byte_op = (running == CMD_WRITE) || (running == CMD_READ) ||
                          (running == CMD_MEASURE && (meas_step == SEQ_SKIP1 ||
                           meas_step == SEQ_CONV || meas_step == SEQ_SKIP2 ||
                           meas_step == SEQ_RDPAD || meas_step == SEQ_LSB ||
                           meas_step == SEQ_MSB));
                if (byte_op && bit_no < 3'd7) begin
                    bit_no = bit_no + 1'b1;
                    enter_phase(PH_SLOT);
                end else if (running == CMD_RESET || running == CMD_WRITE) begin
                    r.done = 1'b1;
                end else if (running == CMD_READ) begin
                    r.done      = 1'b1;
                    r.read_data = {8'h00, shifter};
                end else if (running == CMD_BIT) begin
                    r.done      = 1'b1;
                    r.read_data = {15'd0, shifter[7]};
                end else begin
                    case (meas_step)
                        SEQ_RST1: begin
                            meas_step = SEQ_SKIP1;
                            start_byte(ROM_SKIP);
                        end
                        SEQ_SKIP1: begin
                            meas_step = SEQ_CONV;
                            start_byte(FN_CONVERT);
                        end
                        SEQ_CONV: begin
                            meas_step = SEQ_POLL;
                            shifter   = '0;
                            enter_phase(PH_SLOT);
                        end
                        SEQ_POLL: begin
                            if (shifter[7]) begin
                                meas_step = SEQ_RST2;
                                enter_phase(PH_RLOW);
                            end else begin
                                shifter = '0;
                                enter_phase(PH_SLOT);
                            end
                        end
                        SEQ_RST2: begin
                            meas_step = SEQ_SKIP2;
                            start_byte(ROM_SKIP);
                        end
                        SEQ_SKIP2: begin
                            meas_step = SEQ_RDPAD;
                            start_byte(FN_READ_PAD);
                        end
                        SEQ_RDPAD: begin
                            meas_step = SEQ_LSB;
                            start_byte(8'h00);
                        end
                        SEQ_LSB: begin
                            temp_raw  = {8'h00, shifter};
                            meas_step = SEQ_MSB;
                            start_byte(8'h00);
                        end
                        SEQ_MSB: begin
                            temp_raw  = {shifter, temp_raw[7:0]};
                            meas_step = SEQ_RST3;
                            enter_phase(PH_RLOW);
                        end
                        default: begin
                            r.done      = 1'b1;
                            r.read_data = temp_raw;
                        end
                    endcase
                end
                if (r.done) begin
                    running   = CMD_NONE;
                    meas_step = SEQ_IDLE;
                    enter_phase(PH_IDLE);
                end
            end
        end
        r.busy     = running != CMD_NONE;
        r.presence = device_seen;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_REPORTS)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic send_word(input logic [2:0] act, input logic [7:0] data,
                             input logic line, input bit known, input result_t want);
        result_t r;
        int      gap;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, line, data};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = bus_master_step(act, data, line);
        owed_results.push_back(known ? want : r);
    endtask

    task automatic finish_command();
        while (running != CMD_NONE)
            send_word(ACT_TICK, 8'($urandom), 1'($urandom), 1'b0, RES_IDLE);
    endtask

    // finish any running command, then stop sending until every word has come back
    task automatic quiesce();
        finish_command();
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_timing(input timing_t t);
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_wdata <= t[i];
            @(posedge aclk);
            lim_us[i] = t[i];
        end
        cfg_index <= REG_SPARE;
        cfg_wdata <= 10'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(result_t)-1:0];
            if (owed_results.size() == 0) begin
                note_mismatch("unexpected word", int'(got), 0);
            end else begin
                want = owed_results.pop_front();
                if (got.drive !== want.drive)
                    note_mismatch("drive_low", int'(got.drive), int'(want.drive));
                if (got.busy !== want.busy)
                    note_mismatch("busy", int'(got.busy), int'(want.busy));
                if (got.done !== want.done)
                    note_mismatch("done", int'(got.done), int'(want.done));
                if (got.presence !== want.presence)
                    note_mismatch("presence", int'(got.presence), int'(want.presence));
                if (got.read_data !== want.read_data)
                    note_mismatch("read_data", int'(got.read_data), int'(want.read_data));
                if (got.rejected !== want.rejected)
                    note_mismatch("rejected", int'(got.rejected), int'(want.rejected));
            end
        end
    end

    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        #400_000;
        $display("FAIL onewire_master_temp_reader");
        $finish;
    end

    initial begin
        dir_row_t   plan [19];
        timing_t    t;
        int         counted;
        int         pick;
        logic [2:0] act;
        bit         was_busy;

        plan = '{
            '{ACT_TICK,     8'h00, 1'b0, 1'b1, RES_IDLE,      1'b0, TS_KEEP},
            '{ACT_TICK,     8'hFF, 1'b1, 1'b1, RES_IDLE,      1'b0, TS_KEEP},
            '{ACT_SPARE_LO, 8'h5A, 1'b1, 1'b1, RES_IDLE,      1'b0, TS_KEEP},
            '{ACT_SPARE_HI, 8'hA5, 1'b0, 1'b1, RES_IDLE,      1'b0, TS_KEEP},
            '{CMD_BIT,      8'h00, 1'b1, 1'b1, RES_SLOT_OPEN, 1'b0, TS_KEEP},
            '{CMD_WRITE,    8'hA5, 1'b1, 1'b1, RES_REJECTED,  1'b0, TS_KEEP},
            '{CMD_MEASURE,  8'h3C, 1'b0, 1'b1, RES_REJECTED,  1'b1, TS_KEEP},
            '{CMD_RESET,    8'h00, 1'b0, 1'b0, RES_IDLE,      1'b1, TS_ZERO},
            '{CMD_WRITE,    8'hFF, 1'b1, 1'b0, RES_IDLE,      1'b1, TS_KEEP},
            '{CMD_WRITE,    8'h00, 1'b0, 1'b0, RES_IDLE,      1'b1, TS_KEEP},
            '{CMD_READ,     8'h00, 1'b1, 1'b0, RES_IDLE,      1'b1, TS_KEEP},
            '{CMD_READ,     8'hFF, 1'b0, 1'b0, RES_IDLE,      1'b1, TS_KEEP},
            '{CMD_BIT,      8'h00, 1'b1, 1'b0, RES_IDLE,      1'b1, TS_KEEP},
            '{CMD_BIT,      8'hFF, 1'b0, 1'b0, RES_IDLE,      1'b1, TS_KEEP},
            '{CMD_MEASURE,  8'h00, 1'b1, 1'b0, RES_IDLE,      1'b1, TS_KEEP},
            '{CMD_RESET,    8'h00, 1'b1, 1'b0, RES_IDLE,      1'b1, TS_LONG},
            '{CMD_BIT,      8'h00, 1'b0, 1'b0, RES_IDLE,      1'b1, TS_KEEP},
            '{CMD_WRITE,    8'h96, 1'b1, 1'b0, RES_IDLE,      1'b1, TS_KEEP},
            '{CMD_MEASURE,  8'h00, 1'b1, 1'b0, RES_IDLE,      1'b1, TS_ONE}
        };

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_TICK;
        cfg_we    <= 1'b0;
        cfg_index <= REG_RESET_LOW;
        cfg_wdata <= '0;

        lim_us      = {DEF_READ_RECOVER, DEF_READ_SAMPLE, DEF_WRITE_SLOT, DEF_SLOT_START,
                       DEF_RESET_RECOVER, DEF_PRESENCE_WAIT, DEF_RESET_LOW};
        bus_phase   = PH_IDLE;
        us_count    = '0;
        bit_no      = '0;
        shifter     = '0;
        meas_step   = SEQ_IDLE;
        temp_raw    = '0;
        device_seen = 1'b0;
        running     = CMD_NONE;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].timing_set != TS_KEEP) begin
                quiesce();
                case (plan[i].timing_set)
                    TS_ZERO: load_timing(ZERO_TIMING);
                    TS_LONG: load_timing(LONG_TIMING);
                    default: load_timing(ONE_TIMING);
                endcase
            end
            send_word(plan[i].act, plan[i].data, plan[i].line, plan[i].known, plan[i].want);
            if (plan[i].settle) finish_command();
        end

        // random streams; the last phase runs with longer slot timings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int k = 0; k < NUM_REGS; k++)
                t[k] = (ph == RAND_PHASES - 1) ? 10'($urandom_range(0, 6))
                                               : 10'($urandom_range(0, 3));
            quiesce();
            load_timing(t);
            counted = 0;
            while (counted < PHASE_WORDS) begin
                was_busy = running != CMD_NONE;
                pick = $urandom_range(0, 19);
                if (!was_busy) begin
                    if (pick < 16) begin
                        act = 3'($urandom_range(CMD_RESET, CMD_MEASURE + 1));
                        if (act > CMD_MEASURE) act = CMD_MEASURE;
                    end else if (pick < 18) begin
                        act = ACT_TICK;
                    end else begin
                        act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
                    end
                end else if (pick == 0) begin
                    act = 3'($urandom_range(CMD_RESET, CMD_MEASURE));
                end else if (pick == 1) begin
                    act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
                end else begin
                    act = ACT_TICK;
                end
                send_word(act, 8'($urandom), 1'($urandom), 1'b0, RES_IDLE);
                if (was_busy || (act >= CMD_RESET && act <= CMD_MEASURE)) counted++;
            end
        end

        quiesce();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS onewire_master_temp_reader");
        else
            $display("FAIL onewire_master_temp_reader");
        $finish;
    end

endmodule
